@@ rtl/core/llab_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llab_pkg: shared types and table builders for the linear-light blend
// Holds the sRGB transfer tables, built exactly in integers at elaboration,
// and the queue status type.
// ----------------------------------------------------------------------------
package llab_pkg;

  localparam int TBL_W     = 24;
  localparam int BIG_W     = 320;
  localparam int SRGB_DEN  = 10761;
  localparam int SRGB_OFS  = 561;
  localparam int SRGB_STEP = 20;
  localparam int LIN_KNEE  = 20;

  typedef logic [BIG_W-1:0] big_t;
  typedef logic [255:0][TBL_W-1:0] lin_tbl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic big_t big_pow(big_t base, int e);
    big_t r;
    r = big_t'(1);
    for (int i = 0; i < e; i++) begin
      r = r * base;
    end
    return r;
  endfunction

  // nearest linear value of the transfer curve at k/510
  function automatic logic [31:0] lin_round(int unsigned k, int lb);
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    big_t        den12;
    big_t        rhs;
    big_t        lhs;
    m = (64'd1 << lb) - 64'd1;
    if (k <= LIN_KNEE) begin
      return 32'((64'(k) * 64'd50 * m + 64'd164730) / 64'd329460);
    end
    den12 = big_pow(big_t'(SRGB_DEN), 12);
    rhs   = big_pow(big_t'(SRGB_STEP * k + SRGB_OFS), 12) * big_pow(big_t'(2 * m), 5);
    lo    = '0;
    hi    = m;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      lhs = big_pow(big_t'(2 * mid - 64'd1), 5) * den12;
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return 32'(lo);
  endfunction

  // smallest linear value at or above the transfer curve at k/510
  function automatic logic [31:0] lin_ceil(int unsigned k, int lb);
    logic [63:0] m;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    big_t        den12;
    big_t        rhs;
    big_t        lhs;
    m = (64'd1 << lb) - 64'd1;
    if (k <= LIN_KNEE) begin
      return 32'((64'(k) * 64'd25 * m + 64'd164729) / 64'd164730);
    end
    den12 = big_pow(big_t'(SRGB_DEN), 12);
    rhs   = big_pow(big_t'(SRGB_STEP * k + SRGB_OFS), 12) * big_pow(big_t'(m), 5);
    lo    = '0;
    hi    = m;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      lhs = big_pow(big_t'(mid), 5) * den12;
      if (lhs >= rhs) begin
        hi = mid;
      end else begin
        lo = mid + 64'd1;
      end
    end
    return 32'(lo);
  endfunction

  function automatic lin_tbl_t build_decode(int lb);
    lin_tbl_t t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i] = TBL_W'(lin_round(2 * i, lb));
    end
    return t;
  endfunction

  // code n is chosen when linear value reaches entry n
  function automatic lin_tbl_t build_thresh(int lb);
    lin_tbl_t t;
    t = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = TBL_W'(lin_ceil(2 * i - 1, lb));
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/llab_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llab_if: stream channels of the linear-light blend
// Valid/ready channels for color pairs in and blended colors out.
// ----------------------------------------------------------------------------
interface llab_in_if #(
  parameter int FRAC_W = 17
) ();
  logic              valid;
  logic              ready;
  logic [31:0]       from_color;
  logic [31:0]       to_color;
  logic [FRAC_W-1:0] fraction;

  modport source (output valid, output from_color, output to_color, output fraction,
                  input ready);
  modport sink   (input valid, input from_color, input to_color, input fraction,
                  output ready);
endinterface

interface llab_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] blended_color;

  modport source (output valid, output blended_color, input ready);
  modport sink   (input valid, input blended_color, output ready);
endinterface
`default_nettype wire

@@ rtl/core/llab_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llab_front: input stage of the linear-light blend
// Accepts a transaction, clamps the fraction and decodes the color channels
// to linear light through the decode table.
// ----------------------------------------------------------------------------
module llab_front #(
  parameter int FRACTION_BITS = 16,
  parameter int LINEAR_BITS   = 16,
  parameter int ENTRY_W       = FRACTION_BITS + 1 + 16 + 6 * LINEAR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  llab_in_if.sink                 in_chan,
  input  llab_pkg::q_stat_t       q_stat,
  output logic                    push,
  output logic [ENTRY_W-1:0]      push_data
);

  localparam int FW = FRACTION_BITS + 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;
  localparam llab_pkg::lin_tbl_t DEC_TBL = llab_pkg::build_decode(LINEAR_BITS);

  logic                        vld_r;
  logic [FW-1:0]               frac_r;
  logic [7:0]                  afrom_r;
  logic [7:0]                  ato_r;
  logic [2:0][LINEAR_BITS-1:0] lf_r;
  logic [2:0][LINEAR_BITS-1:0] lt_r;
  logic [FW-1:0]               frac_in;
  logic                        accept;

  assign in_chan.ready = !vld_r || !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = vld_r && !q_stat.full;
  assign push_data     = {frac_r, afrom_r, ato_r, lf_r, lt_r};
  assign frac_in       = FW'(in_chan.fraction);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac_r  <= (frac_in > ONE) ? ONE : frac_in;
      afrom_r <= in_chan.from_color[31:24];
      ato_r   <= in_chan.to_color[31:24];
      for (int l = 0; l < 3; l++) begin
        lf_r[l] <= DEC_TBL[in_chan.from_color[8*l +: 8]][LINEAR_BITS-1:0];
        lt_r[l] <= DEC_TBL[in_chan.to_color[8*l +: 8]][LINEAR_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/llab_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llab_queue: small register queue between front and back
// First-in first-out store of decoded items with full and empty status.
// ----------------------------------------------------------------------------
module llab_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output llab_pkg::q_stat_t     stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/llab_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llab_back: blend and encode pipeline
// Interpolates four lanes, then finds each color code by an eight-step
// pipelined search of the threshold table.
// ----------------------------------------------------------------------------
module llab_back #(
  parameter int FRACTION_BITS = 16,
  parameter int LINEAR_BITS   = 16,
  parameter int ENTRY_W       = FRACTION_BITS + 1 + 16 + 6 * LINEAR_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  llab_pkg::q_stat_t       q_stat,
  input  logic [ENTRY_W-1:0]      pop_data,
  output logic                    pop,
  llab_out_if.source              out_chan
);

  localparam int LB = LINEAR_BITS;
  localparam int FW = FRACTION_BITS + 1;
  localparam int PW = LB + FW + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
  localparam llab_pkg::lin_tbl_t THR_TBL = llab_pkg::build_thresh(LINEAR_BITS);

  logic advance;

  // unpacked queue entry, lane 3 is alpha
  logic [FW-1:0]           frac;
  logic [3:0][LB-1:0]      x_c;
  logic [3:0][LB-1:0]      y_c;
  logic signed [LB:0]      d_c [4];
  logic signed [FW:0]      fs_c;

  logic                    a_vld_r;
  logic signed [PW-1:0]    prod_r [4];
  logic [3:0][LB-1:0]      base_r;

  logic signed [PW-1:0]    q_c [4];
  logic [3:0][LB-1:0]      mix_c;

  logic                    s_vld_r   [9];
  logic [2:0][LB-1:0]      s_lin_r   [9];
  logic [2:0][7:0]         s_code_r  [9];
  logic [7:0]              s_alpha_r [9];

  logic                    out_vld_r;
  logic [31:0]             out_data_r;

  assign advance                = !out_vld_r || out_chan.ready;
  assign pop                    = advance && !q_stat.empty;
  assign out_chan.valid         = out_vld_r;
  assign out_chan.blended_color = out_data_r;

  always_comb begin
    frac = pop_data[ENTRY_W-1 -: FW];
    for (int l = 0; l < 3; l++) begin
      y_c[l] = pop_data[LB*l +: LB];
      x_c[l] = pop_data[3*LB + LB*l +: LB];
    end
    y_c[3] = LB'(pop_data[6*LB +: 8]);
    x_c[3] = LB'(pop_data[6*LB + 8 +: 8]);
    fs_c   = $signed({1'b0, frac});
    for (int l = 0; l < 4; l++) begin
      d_c[l] = $signed({1'b0, y_c[l]}) - $signed({1'b0, x_c[l]});
    end
  end

  // x + (y - x) * f, the product registered here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (advance) begin
      a_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int l = 0; l < 4; l++) begin
        prod_r[l] <= PW'(d_c[l]) * PW'(fs_c);
      end
      base_r <= x_c;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      q_c[l]   = (prod_r[l] + HALF) >>> FRACTION_BITS;
      mix_c[l] = LB'($signed({{(PW - LB){1'b0}}, base_r[l]}) + q_c[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r[0] <= 1'b0;
    end else if (advance) begin
      s_vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int l = 0; l < 3; l++) begin
        s_lin_r[0][l]  <= mix_c[l];
        s_code_r[0][l] <= '0;
      end
      s_alpha_r[0] <= mix_c[3][7:0];
    end
  end

  // one code bit per stage, msb first
  for (genvar s = 0; s < 8; s++) begin : g_search
    logic [2:0][7:0] code_nxt;
    logic [2:0][7:0] cand;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cand[l] = s_code_r[s][l] | (8'd1 << (7 - s));
        if (s_lin_r[s][l] >= THR_TBL[cand[l]][LB-1:0]) begin
          code_nxt[l] = cand[l];
        end else begin
          code_nxt[l] = s_code_r[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_vld_r[s+1] <= 1'b0;
      end else if (advance) begin
        s_vld_r[s+1] <= s_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        s_lin_r[s+1]   <= s_lin_r[s];
        s_code_r[s+1]  <= code_nxt;
        s_alpha_r[s+1] <= s_alpha_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s_vld_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {s_alpha_r[8], s_code_r[8][2], s_code_r[8][1], s_code_r[8][0]};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/linear_light_argb_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// linear_light_argb_blend: ARGB8888 blend in linear light
// Throughput one transaction per cycle while the output is ready, set by the
// fully pipelined blend and code search. A registered decode stage feeds a
// QUEUE_DEPTH entry queue ahead of the back end, so input and output stall
// independently. Synchronous active-low reset empties the queue and clears all
// valid flags; no init sweep is needed.
// ----------------------------------------------------------------------------
module linear_light_argb_blend #(
  parameter int FRACTION_BITS = 16,
  parameter int LINEAR_BITS   = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  llab_in_if.sink     in_chan,
  llab_out_if.source  out_chan
);

  localparam int ENTRY_W = FRACTION_BITS + 1 + 16 + 6 * LINEAR_BITS;

  llab_pkg::q_stat_t    q_stat;
  logic                 push;
  logic                 pop;
  logic [ENTRY_W-1:0]   push_data;
  logic [ENTRY_W-1:0]   pop_data;

  llab_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .LINEAR_BITS   (LINEAR_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  llab_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  llab_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .LINEAR_BITS   (LINEAR_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

@@ test/linear_light_argb_blend_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_light_argb_blend_test: self-checking bench for the linear-light blend
// Feeds color pairs and blend fractions through the valid/ready channels and
// compares every blended color against a predictor. The predictor builds its
// sRGB decode and code-threshold tables in exact integer arithmetic. Both
// sides idle at random in several mixes, and the sink also holds off for a
// long stretch.
// ----------------------------------------------------------------------------
module linear_light_argb_blend_test;

  localparam int unsigned FRAC_ONE     = 32'h1_0000;
  localparam int unsigned LIN_FULL     = 32'hFFFF;
  localparam int unsigned CURVE_DEN    = 10761;
  localparam int unsigned CURVE_OFS    = 561;
  localparam int unsigned CURVE_STEP   = 20;
  localparam int unsigned KNEE_K       = 20;
  localparam int          RANDOM_ITEMS = 210;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PRINT_LIMIT  = 40;

  typedef logic [319:0] wide_t;

  class blend_scoreboard;
    logic [15:0] decode_lut [256];
    logic [15:0] code_threshold [256];
    logic [31:0] expected_colors [$];
    int          mismatches;
    int          results_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
      code_threshold[0] = '0;
      for (int i = 0; i < 256; i++) begin
        decode_lut[i] = linear_nearest(2 * i);
      end
      for (int i = 1; i < 256; i++) begin
        code_threshold[i] = linear_ceiling(2 * i - 1);
      end
    endfunction

    function wide_t raise(wide_t base, int e);
      wide_t acc;
      acc = wide_t'(1);
      for (int i = 0; i < e; i++) begin
        acc = acc * base;
      end
      return acc;
    endfunction

    // nearest linear value of the transfer curve at k/510
    // above the knee: ((2L-1)/2M)^5 <= ((20k+561)/10761)^12
    function logic [15:0] linear_nearest(int unsigned k);
      wide_t       den12;
      wide_t       curve;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      if (k <= KNEE_K) begin
        return 16'((64'(k) * 64'd50 * 64'(LIN_FULL) + 64'd164730) / 64'd329460);
      end
      den12 = raise(wide_t'(CURVE_DEN), 12);
      curve = raise(wide_t'(CURVE_STEP * k + CURVE_OFS), 12) * raise(wide_t'(2 * LIN_FULL), 5);
      lo    = '0;
      hi    = LIN_FULL;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (raise(wide_t'(2 * mid - 1), 5) * den12 <= curve) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      return lo[15:0];
    endfunction

    // smallest linear value at or above the curve at k/510
    function logic [15:0] linear_ceiling(int unsigned k);
      wide_t       den12;
      wide_t       curve;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      if (k <= KNEE_K) begin
        return 16'((64'(k) * 64'd25 * 64'(LIN_FULL) + 64'd164729) / 64'd164730);
      end
      den12 = raise(wide_t'(CURVE_DEN), 12);
      curve = raise(wide_t'(CURVE_STEP * k + CURVE_OFS), 12) * raise(wide_t'(LIN_FULL), 5);
      lo    = '0;
      hi    = LIN_FULL;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (raise(wide_t'(mid), 5) * den12 >= curve) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      return lo[15:0];
    endfunction

    function logic [7:0] encode_code(logic [15:0] lin);
      logic [7:0] code;
      code = '0;
      for (int i = 1; i < 256; i++) begin
        if (lin >= code_threshold[i]) begin
          code = 8'(i);
        end
      end
      return code;
    endfunction

    // half-up rounded interpolation, fraction clipped to one
    function logic [15:0] mix(logic [16:0] frac, logic [15:0] a, logic [15:0] b);
      logic [40:0] f;
      logic [40:0] s;
      f = (frac > FRAC_ONE) ? 41'(FRAC_ONE) : 41'(frac);
      s = 41'(a) * (41'(FRAC_ONE) - f) + 41'(b) * f + 41'(FRAC_ONE / 2);
      return 16'(s >> 16);
    endfunction

    function logic [31:0] linear_blend(logic [31:0] from_c, logic [31:0] to_c,
                                       logic [16:0] frac);
      logic [31:0] color;
      logic [15:0] lin;
      lin = mix(frac, 16'(from_c[31:24]), 16'(to_c[31:24]));
      color[31:24] = lin[7:0];
      for (int sh = 0; sh < 24; sh += 8) begin
        lin = mix(frac, decode_lut[from_c[sh +: 8]], decode_lut[to_c[sh +: 8]]);
        color[sh +: 8] = encode_code(lin);
      end
      return color;
    endfunction

    function void note_input(logic [31:0] from_c, logic [31:0] to_c, logic [16:0] frac);
      expected_colors.push_back(linear_blend(from_c, to_c, frac));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
        $display("%0t mismatch: %s", $realtime, what);
      end
    endtask

    task check_result(logic [31:0] got);
      logic [31:0] want;
      results_seen++;
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected blended_color %08h", got));
        return;
      end
      want = expected_colors.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("result %0d blended_color %08h, expected %08h",
                                  results_seen, got, want));
      end
    endtask

    task finish_check();
      if (expected_colors.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  llab_in_if #(.FRAC_W(17)) in_chan ();
  llab_out_if out_chan ();

  linear_light_argb_blend dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  blend_scoreboard color_board;
  int send_idle_pct = 19;
  int recv_idle_pct = 71;
  bit hold_request  = 1'b0;
  int hold_left;
  int quiet_cycles  = 0;
  int inputs_sent   = 0;
  int input_stalls  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink side: random idling plus one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        color_board.note_input(in_chan.from_color, in_chan.to_color, in_chan.fraction);
      end
      if (in_chan.valid && !in_chan.ready) begin
        input_stalls++;
      end
      if (out_chan.valid && out_chan.ready) begin
        color_board.check_result(out_chan.blended_color);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] from_c, input logic [31:0] to_c,
                           input logic [16:0] frac);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.from_color <= from_c;
    in_chan.to_color   <= to_c;
    in_chan.fraction   <= frac;
    @(posedge clk);
    while (!in_chan.ready) begin
      @(posedge clk);
    end
    inputs_sent++;
  endtask

  // extremes and near-knee codes show up often
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(12));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    return {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
  endfunction

  function automatic logic [16:0] pick_fraction();
    case ($urandom_range(11))
      0:       return 17'd0;
      1:       return 17'(FRAC_ONE);
      2:       return 17'($urandom_range(131071, 65537));
      3:       return 17'($urandom_range(16));
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  task automatic run_random(input int count);
    logic [31:0] from_c;
    logic [31:0] to_c;
    repeat (count) begin
      from_c = pick_color();
      to_c   = ($urandom_range(9) == 0) ? from_c : pick_color();
      send_item(from_c, to_c, pick_fraction());
    end
  endtask

  initial begin
    color_board        = new();
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.from_color = '0;
    in_chan.to_color   = '0;
    in_chan.fraction   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end points, midpoints, knee codes and fractions above one
    send_item(32'h0000_0000, 32'h0000_0000, 17'd0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd65536);
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 17'd32768);
    send_item(32'hFFFF_FFFF, 32'h0000_0000, 17'd32768);
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 17'd1);
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 17'd65535);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 17'd0);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 17'd65536);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 17'd65537);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 17'h1FFFF);
    send_item(32'h0000_0A0B, 32'h000B_0A00, 17'd16384);
    send_item(32'h800A_0A0A, 32'h8000_0000, 17'd49152);
    send_item(32'hFF0B_0B0B, 32'h0015_1515, 17'd30000);
    send_item(32'hFF00_0000, 32'h00FF_FFFF, 17'h18000);
    send_item(32'h00FF_00FF, 32'hFF00_FF00, 17'd21845);
    send_item(32'h0101_0101, 32'hFEFE_FEFE, 17'd43690);
    send_item(32'h7F80_8081, 32'h8081_7F7E, 17'd32768);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 17'd65535);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 17'h1AAAA);
    send_item(32'h0004_0302, 32'h0002_0304, 17'd65535);

    run_random(RANDOM_ITEMS);
    send_idle_pct = 71;
    recv_idle_pct = 19;
    run_random(RANDOM_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // sink stalls long enough for the queue to fill and block the input
    hold_request  = 1'b1;
    run_random(RANDOM_ITEMS);

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (color_board.expected_colors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    color_board.finish_check();

    $display("sent %0d color pairs, checked %0d blended colors, %0d mismatches",
             inputs_sent, color_board.results_seen, color_board.mismatches);
    $display("input held off for %0d cycles under sink backpressure", input_stalls);
    if (color_board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
